// ===== rtl/core/apdt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apdt_pkg
// Shared types and constants of the peer discovery table with aging.
// ----------------------------------------------------------------------------
package apdt_pkg;

  localparam int TIME_W      = 32;
  localparam int HOST_W      = 32;
  localparam int PORT_W      = 16;
  localparam int PLAYER_W    = 8;
  localparam int INDEX_W     = 6;
  localparam int ENTRY_CNT_W = 7;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_PROBE_INTERVAL = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_AGE        = 2'd1;

  localparam logic [TIME_W-1:0] PROBE_INTERVAL_RESET = 32'd1000;
  localparam logic [TIME_W-1:0] MAX_AGE_RESET        = 32'd5000;

  localparam logic ACT_UPDATE = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  typedef struct packed {
    logic                action;
    logic [TIME_W-1:0]   now;
    logic                send_failed;
    logic                reply_valid;
    logic [HOST_W-1:0]   reply_host;
    logic [PORT_W-1:0]   reply_port;
    logic [PLAYER_W-1:0] reply_current;
    logic [PLAYER_W-1:0] reply_maximum;
    logic [INDEX_W-1:0]  read_index;
  } in_item_t;

  typedef struct packed {
    logic                   probe_due;
    logic [ENTRY_CNT_W-1:0] entry_count;
    logic                   read_hit;
    logic [HOST_W-1:0]      read_host;
    logic [PORT_W-1:0]      read_port;
    logic [PLAYER_W-1:0]    read_current;
    logic [PLAYER_W-1:0]    read_maximum;
  } out_item_t;

  // One stored peer record.
  typedef struct packed {
    logic [HOST_W-1:0]   host;
    logic [PORT_W-1:0]   port;
    logic [PLAYER_W-1:0] current;
    logic [PLAYER_W-1:0] maximum;
    logic [TIME_W-1:0]   stamp;
  } entry_t;

endpackage

// ===== rtl/core/apdt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apdt_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module apdt_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/apdt_age_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apdt_age_unit
// Shared elapsed-time unit: (now - ref_time) mod 2^32 compared to a limit.
// ----------------------------------------------------------------------------
module apdt_age_unit (
  input  logic [apdt_pkg::TIME_W-1:0] now,
  input  logic [apdt_pkg::TIME_W-1:0] ref_time,
  input  logic [apdt_pkg::TIME_W-1:0] limit,
  input  logic                        strict,
  output logic                        hit
);

  import apdt_pkg::*;

  logic [TIME_W-1:0] elapsed;

  // Strict compares for entry expiry, non-strict for the probe interval.
  always_comb begin
    elapsed = now - ref_time;
    hit     = strict ? (elapsed > limit) : (elapsed >= limit);
  end

endmodule

// ===== rtl/core/aging_peer_discovery_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aging_peer_discovery_table_top
// Peer discovery table with probe timing, learning of replies and aging.
// ----------------------------------------------------------------------------
// One transaction is processed at a time; the input is ready again once the
// previous result has been placed in the output register. A read fetches the
// entry only when the index is below the entry count. An update first checks
// the probe interval and ends there if a due probe failed to send. Otherwise a
// valid reply is compared against each entry's host and port in turn; it is
// written over a matching entry, or appended when none matches and there is
// room. Then every entry present when aging starts is checked exactly once.
// Entries are visited one at a time, since the entry memory has a single read
// port and the one elapsed-time comparator is shared. Back-pressure on the
// output holds the result in the output register until it is taken. No
// clearing pass is needed after reset.
module aging_peer_discovery_table_top #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  apdt_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output apdt_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [apdt_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [apdt_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import apdt_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_READ      = 4'd1;
  localparam logic [3:0] S_READ_DATA = 4'd2;
  localparam logic [3:0] S_PROBE     = 4'd3;
  localparam logic [3:0] S_SRCH_ADDR = 4'd4;
  localparam logic [3:0] S_SRCH_CMP  = 4'd5;
  localparam logic [3:0] S_AGE_ADDR  = 4'd6;
  localparam logic [3:0] S_AGE_CMP   = 4'd7;
  localparam logic [3:0] S_MOVE      = 4'd8;
  localparam logic [3:0] S_DONE      = 4'd9;

  logic [3:0]        state;
  in_item_t          item;
  logic [CW-1:0]     live_count;
  logic [CW-1:0]     idx;
  logic [TIME_W-1:0] last_probe_time;
  logic [TIME_W-1:0] probe_interval;
  logic [TIME_W-1:0] max_age;
  logic              due;
  logic              rd_hit;
  entry_t            rd_entry;

  logic              we;
  logic [AW-1:0]     waddr;
  entry_t            wdata;
  logic [AW-1:0]     raddr;
  logic [$bits(entry_t)-1:0] rdata_raw;
  entry_t            rdata;

  logic [TIME_W-1:0] unit_ref;
  logic [TIME_W-1:0] unit_limit;
  logic              unit_strict;
  logic              unit_hit;

  logic [CW+INDEX_W-1:0] req_wide;
  logic [CW+INDEX_W-1:0] cnt_wide;
  logic [AW+INDEX_W-1:0] req_addr_wide;
  logic                  req_in_range;
  logic [CW-1:0]         last_pos;
  logic [CW+ENTRY_CNT_W-1:0] cnt_out_wide;
  entry_t                new_entry;
  logic                  idx_live;

  assign rdata = rdata_raw;

  always_comb begin
    req_wide      = {{CW{1'b0}}, item.read_index};
    cnt_wide      = {{INDEX_W{1'b0}}, live_count};
    req_in_range  = req_wide < cnt_wide;
    req_addr_wide = {{AW{1'b0}}, item.read_index};
    last_pos      = live_count - {{(CW-1){1'b0}}, 1'b1};
    cnt_out_wide  = {{ENTRY_CNT_W{1'b0}}, live_count};
    idx_live      = idx < live_count;
    new_entry     = '{host: item.reply_host, port: item.reply_port,
                      current: item.reply_current, maximum: item.reply_maximum,
                      stamp: item.now};
  end

  // The comparator serves the probe check and every expiry check.
  always_comb begin
    if (state == S_PROBE) begin
      unit_ref    = last_probe_time;
      unit_limit  = probe_interval;
      unit_strict = 1'b0;
    end else begin
      unit_ref    = rdata.stamp;
      unit_limit  = max_age;
      unit_strict = 1'b1;
    end
  end

  apdt_age_unit u_age (
    .now      (item.now),
    .ref_time (unit_ref),
    .limit    (unit_limit),
    .strict   (unit_strict),
    .hit      (unit_hit)
  );

  always_comb begin
    we    = 1'b0;
    waddr = idx[AW-1:0];
    wdata = new_entry;
    raddr = idx[AW-1:0];
    unique case (state)
      S_READ: begin
        raddr = req_addr_wide[AW-1:0];
      end
      S_SRCH_ADDR: begin
        if (!idx_live && live_count < CW'(TABLE_DEPTH)) begin
          we    = 1'b1;
          waddr = live_count[AW-1:0];
        end
      end
      S_SRCH_CMP: begin
        if (rdata.host == item.reply_host && rdata.port == item.reply_port) begin
          we = 1'b1;
        end
      end
      S_AGE_CMP: begin
        raddr = last_pos[AW-1:0];
      end
      S_MOVE: begin
        we    = 1'b1;
        wdata = rdata;
      end
      default: begin
      end
    endcase
  end

  apdt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_interval <= PROBE_INTERVAL_RESET;
      max_age        <= MAX_AGE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PROBE_INTERVAL: probe_interval <= cfg_data;
        CFG_MAX_AGE:        max_age        <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      live_count      <= '0;
      last_probe_time <= '0;
      out_valid       <= 1'b0;
    end else begin
      // In S_DONE the result register is refilled below whenever it drains.
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item     <= in_data;
            due      <= 1'b0;
            rd_hit   <= 1'b0;
            rd_entry <= '0;
            idx      <= '0;
            state    <= (in_data.action == ACT_READ) ? S_READ : S_PROBE;
          end
        end
        S_READ: begin
          state <= req_in_range ? S_READ_DATA : S_DONE;
        end
        S_READ_DATA: begin
          rd_hit   <= 1'b1;
          rd_entry <= rdata;
          state    <= S_DONE;
        end
        S_PROBE: begin
          due <= unit_hit;
          if (unit_hit && item.send_failed) begin
            state <= S_DONE;
          end else begin
            if (unit_hit) begin
              last_probe_time <= item.now;
            end
            state <= item.reply_valid ? S_SRCH_ADDR : S_AGE_ADDR;
          end
        end
        S_SRCH_ADDR: begin
          if (idx_live) begin
            state <= S_SRCH_CMP;
          end else begin
            // No match: the reply is appended when there is room.
            if (live_count < CW'(TABLE_DEPTH)) begin
              live_count <= live_count + {{(CW-1){1'b0}}, 1'b1};
            end
            idx   <= '0;
            state <= S_AGE_ADDR;
          end
        end
        S_SRCH_CMP: begin
          if (we) begin
            idx   <= '0;
            state <= S_AGE_ADDR;
          end else begin
            idx   <= idx + {{(CW-1){1'b0}}, 1'b1};
            state <= S_SRCH_ADDR;
          end
        end
        S_AGE_ADDR: begin
          state <= idx_live ? S_AGE_CMP : S_DONE;
        end
        S_AGE_CMP: begin
          if (unit_hit) begin
            state <= S_MOVE;
          end else begin
            idx   <= idx + {{(CW-1){1'b0}}, 1'b1};
            state <= S_AGE_ADDR;
          end
        end
        S_MOVE: begin
          // The last entry now sits at idx, which is checked again.
          live_count <= last_pos;
          state      <= S_AGE_ADDR;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid             <= 1'b1;
            out_data.probe_due    <= due;
            out_data.entry_count  <= cnt_out_wide[ENTRY_CNT_W-1:0];
            out_data.read_hit     <= rd_hit;
            out_data.read_host    <= rd_entry.host;
            out_data.read_port    <= rd_entry.port;
            out_data.read_current <= rd_entry.current;
            out_data.read_maximum <= rd_entry.maximum;
            state                 <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
